// ----- hw/rtl/basc_pkg.sv -----
// Package for the binary angle sine and cosine unit: widths, request codes and the quarter-wave table.
`default_nettype none

package basc_pkg;

  // Fraction bits of a table entry and of the result.
  localparam int FRAC_BITS = 15;

  // Request codes.
  localparam logic [1:0] REQ_SIN_COARSE = 2'd0;
  localparam logic [1:0] REQ_COS_COARSE = 2'd1;
  localparam logic [1:0] REQ_SIN_FINE   = 2'd2;
  localparam logic [1:0] REQ_COS_FINE   = 2'd3;

  localparam int ANGLE_W   = 32;
  localparam int REQ_W     = 2;
  localparam int OUT_W     = 17;
  localparam int OUT_MAX   = 65535;
  localparam int OUT_MIN   = -65536;

  // Quarter-wave table: entries 0 to 256 cover 0 to a quarter turn.
  localparam int ROM_DEPTH = 257;
  localparam int ROM_AW    = 9;
  localparam int MAG_W     = FRAC_BITS + 1;

  // Interpolation arithmetic.
  localparam int STEP_W    = 10;
  localparam int FRAC_W    = ANGLE_W - STEP_W;
  localparam int VAL_W     = MAG_W + 1;
  localparam int DIFF_W    = VAL_W + 1;
  localparam int PROD_W    = DIFF_W + FRAC_W + 1;
  localparam int Q_W       = PROD_W - FRAC_W;
  localparam int SUM_W     = Q_W + 1;
  localparam int SAT_W     = (SUM_W > OUT_W + 1) ? SUM_W : OUT_W + 1;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef logic [ROM_DEPTH-1:0][MAG_W-1:0] rom_t;

  // Folded table access: sign of the result and table index.
  typedef struct packed {
    logic              neg;
    logic [ROM_AW-1:0] idx;
  } fold_t;

  // Unsigned long division by shift and subtract, used only while the table is built.
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Builds the table from a Taylor series in 30-bit fixed point.
  function automatic rom_t rom_build();
    rom_t            tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint unsigned rnd;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      x    = (longint'(k) * PI_Q30 + 64'd256) >> 9;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = (term * x2) >> 30;
        term = udiv64(term, 64'((2 * n) * (2 * n + 1)));
        if (n[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      rnd    = (longint'(sum) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      tab[k] = rnd[MAG_W-1:0];
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/basc_rom.sv -----
// Two-port quarter-wave sine table with registered read data.
`default_nettype none

module basc_rom (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [basc_pkg::ROM_AW-1:0]   addr0,
  input  wire logic [basc_pkg::ROM_AW-1:0]   addr1,
  output logic      [basc_pkg::MAG_W-1:0]    data0,
  output logic      [basc_pkg::MAG_W-1:0]    data1
);

  localparam basc_pkg::rom_t TAB = basc_pkg::rom_build();

  // Both ports read on the same enable; data holds while the stage is held.
  always_ff @(posedge clk) begin
    if (en) begin
      data0 <= TAB[addr0];
      data1 <= TAB[addr1];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/binary_angle_sine_cosine.sv -----
// Top level of the binary angle sine and cosine unit with linear interpolation.
`default_nettype none

// Channel  | Direction | Transfer when           | Payload
// ---------+-----------+-------------------------+---------------------------------
// request  | in        | req_valid && !req_stall | req_type[1:0], angle[31:0]
// response | out       | rsp_valid && !rsp_stall | value[16:0] (signed, 2^15 scale)
//
// One request transfer is taken every clock while the response side keeps up.
// After its request transfer, a result passes through the table read, sign and
// difference, multiply, then add and saturate into the output register.
// The two-port table read sets the pace, as both table points of an item are
// fetched in the cycle it enters. Each stage moves on its own, so bubbles close
// up and new requests are taken while a finished result waits on rsp_stall.
// Reset (rst, synchronous) clears only the valid bits; the data registers are not reset.

module binary_angle_sine_cosine (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            req_valid,
  output logic                                 req_stall,
  input  wire logic [basc_pkg::REQ_W-1:0]      req_type,
  input  wire logic [basc_pkg::ANGLE_W-1:0]    angle,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_stall,
  output logic signed [basc_pkg::OUT_W-1:0]    value
);

  // Fold a 16-bit binary angle into the first quadrant: the sign of the result
  // and the table index taken from bits 14:6 of the folded angle.
  function automatic basc_pkg::fold_t fold(input logic [15:0] a);
    basc_pkg::fold_t f;
    logic [15:0]     m;
    if (a[15]) begin
      f.neg = 1'b1;
      if (a < 16'hC000) begin
        m = a - 16'h8000;
      end else begin
        m = 16'h0000 - a;
      end
    end else begin
      f.neg = 1'b0;
      if (a > 16'h4000) begin
        m = 16'h8000 - a;
      end else begin
        m = a;
      end
    end
    f.idx = m[14:6];
    return f;
  endfunction

  // Handshake across the stages.
  logic s1_valid, s2_valid, s3_valid;
  logic out_load, s3_free, s2_free, s1_free;
  logic s3_move, s2_move, s1_move, accept;

  assign out_load  = !rsp_valid || !rsp_stall;
  assign s3_move   = s3_valid && out_load;
  assign s3_free   = !s3_valid || out_load;
  assign s2_move   = s2_valid && s3_free;
  assign s2_free   = !s2_valid || s3_free;
  assign s1_move   = s1_valid && s2_free;
  assign s1_free   = !s1_valid || s2_free;
  assign accept    = req_valid && s1_free;
  assign req_stall = !s1_free;

  // Address generation. The coarse modes round the angle to 16 bits and read
  // one point with no interpolation weight. The fine modes read the 10-bit
  // step below the angle and the one above, weighted by the low 22 bits.
  logic                          is_cos, is_fine;
  logic [15:0]                   coarse_a;
  logic [basc_pkg::STEP_W-1:0]   step0, step1;
  logic [basc_pkg::FRAC_W-1:0]   frac_in;
  basc_pkg::fold_t               f0, f1;

  always_comb begin
    is_cos   = (req_type == basc_pkg::REQ_COS_COARSE) ||
               (req_type == basc_pkg::REQ_COS_FINE);
    is_fine  = (req_type == basc_pkg::REQ_SIN_FINE) ||
               (req_type == basc_pkg::REQ_COS_FINE);
    coarse_a = angle[31:16] + {15'd0, angle[15]} + (is_cos ? 16'h4000 : 16'h0000);
    step0    = angle[31:22] + (is_cos ? 10'h100 : 10'h000);
    step1    = step0 + 10'd1;
    if (is_fine) begin
      f0      = fold({step0, 6'b0});
      f1      = fold({step1, 6'b0});
      frac_in = angle[basc_pkg::FRAC_W-1:0];
    end else begin
      f0      = fold(coarse_a);
      f1      = f0;
      frac_in = '0;
    end
  end

  // Stage 1: table read, with the signs and weight alongside.
  logic [basc_pkg::MAG_W-1:0]  s1_mag0, s1_mag1;
  logic                        s1_neg0, s1_neg1;
  logic [basc_pkg::FRAC_W-1:0] s1_frac;

  basc_rom u_rom (
    .clk   (clk),
    .en    (accept),
    .addr0 (f0.idx),
    .addr1 (f1.idx),
    .data0 (s1_mag0),
    .data1 (s1_mag1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !s2_free);
    end
    if (accept) begin
      s1_neg0 <= f0.neg;
      s1_neg1 <= f1.neg;
      s1_frac <= frac_in;
    end
  end

  // Stage 2: signed values and the difference between the two points.
  logic signed [basc_pkg::VAL_W-1:0]  v0_next, v1_next;
  logic signed [basc_pkg::VAL_W-1:0]  s2_v0;
  logic signed [basc_pkg::DIFF_W-1:0] s2_diff;
  logic [basc_pkg::FRAC_W-1:0]        s2_frac;

  always_comb begin
    v0_next = $signed({1'b0, s1_mag0});
    v1_next = $signed({1'b0, s1_mag1});
    if (s1_neg0) begin
      v0_next = -v0_next;
    end
    if (s1_neg1) begin
      v1_next = -v1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_move || (s2_valid && !s3_free);
    end
    if (s1_move) begin
      s2_v0   <= v0_next;
      s2_diff <= basc_pkg::DIFF_W'(v1_next) - basc_pkg::DIFF_W'(v0_next);
      s2_frac <= s1_frac;
    end
  end

  // Stage 3: slope times weight.
  logic signed [basc_pkg::VAL_W-1:0]  s3_v0;
  logic signed [basc_pkg::PROD_W-1:0] s3_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_move || (s3_valid && !out_load);
    end
    if (s2_move) begin
      s3_v0   <= s2_v0;
      s3_prod <= s2_diff * $signed({1'b0, s2_frac});
    end
  end

  // Stage 4: the arithmetic shift floors the weighted step towards minus
  // infinity; the sum is then clamped to the output range.
  logic signed [basc_pkg::Q_W-1:0]   q;
  logic signed [basc_pkg::SAT_W-1:0] sum;
  logic signed [basc_pkg::OUT_W-1:0] value_next;

  always_comb begin
    q   = s3_prod[basc_pkg::PROD_W-1:basc_pkg::FRAC_W];
    sum = basc_pkg::SAT_W'(s3_v0) + basc_pkg::SAT_W'(q);
    if (sum > $signed(basc_pkg::SAT_W'(basc_pkg::OUT_MAX))) begin
      value_next = $signed(basc_pkg::OUT_W'(basc_pkg::OUT_MAX));
    end else if (sum < $signed(basc_pkg::SAT_W'(basc_pkg::OUT_MIN))) begin
      value_next = $signed(basc_pkg::OUT_W'(basc_pkg::OUT_MIN));
    end else begin
      value_next = sum[basc_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= s3_move || (rsp_valid && rsp_stall);
    end
    if (s3_move) begin
      value <= value_next;
    end
  end

  // A finished item in the last stage reaches the output whenever it is free.
  a_s3_to_out: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && out_load) |=> rsp_valid)
    else $error("result in last stage did not reach the output register");

  // A held result must not let the item behind it vanish.
  a_s3_held: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall && s3_valid) |=> s3_valid)
    else $error("item in last stage lost while the output was held");

  // An empty first stage always takes a request.
  a_s1_open: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !req_stall)
    else $error("request stalled with the first stage empty");

endmodule

`default_nettype wire
